>>> rtl/itoa_pkg.sv
package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 32;

  // quotient bits retired per divider cycle
  localparam int DIV_STEP = 8;

  localparam logic [4:0] BASE_BIN = 5'd2;
  localparam logic [4:0] BASE_DEC = 5'd10;
  localparam logic [4:0] BASE_HEX = 5'd16;

  localparam logic [3:0] DIGIT_TEN   = 4'd10;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_SEND
  } state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < DIGIT_TEN) begin
      return ASCII_ZERO + {4'b0000, d};
    end
    return ASCII_A + {4'b0000, d - DIGIT_TEN};
  endfunction

endpackage

>>> rtl/itoa_if.sv
interface itoa_in_if
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [4:0]                    base;

  modport source (output valid, output value, output base, input ready);
  modport sink   (input valid, input value, input base, output ready);
endinterface

interface itoa_out_if
  import itoa_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

>>> rtl/integer_to_base_ascii_unit.sv
// Integer to ASCII text in radix 2 to 16.
//
// din takes one word: a signed value and a base. Bases 0, 1 and 10 give
// signed decimal with a leading '-', bases 2..9 and 11..16 give the digits
// of the magnitude without sign, bases above 16 act as 16. dout then
// delivers the characters most significant first, one word each, with
// last set on the final one. Zero gives a single '0'.
//
// One item at a time: din.ready is high only when idle. A shared long
// divider retires DIV_STEP quotient bits per cycle, working through the
// whole quotient for each digit. Digits are stored in a small RAM, then
// read back in reverse through its registered port, with a read state
// before each character; any '-' is sent ahead of them. Once the final
// character is taken the unit returns to idle for the next word.
// A stalled dout simply holds the current character; nothing is lost.
// rst (synchronous) returns the sequencer to idle; the digit RAM needs no
// clearing since every entry read was written by the same item.
module integer_to_base_ascii_unit
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input logic        clk,
  input logic        rst,
  itoa_in_if.sink    din,
  itoa_out_if.source dout
);

  localparam int CHUNKS = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int DW     = CHUNKS * DIV_STEP;
  localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CW     = $clog2(MAX_DIGITS + 1);
  localparam int AW     = $clog2(MAX_DIGITS);

  state_t state, state_next;

  logic [DW-1:0]  quo;
  logic [3:0]     rem;
  logic [CKW-1:0] chunk_cnt;
  logic [CW-1:0]  digit_count;
  logic [4:0]     base_r;
  logic           negative;
  logic           decimal;

  logic [3:0]     digit_store [MAX_DIGITS];
  logic [3:0]     rd_data;
  logic [AW-1:0]  rd_addr;

  logic [DW-1:0]          quo_t;
  logic [3:0]             rem_t;
  logic                   chunk_last;
  logic                   room;
  logic [CW-1:0]          count_inc;
  logic                   show_minus;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic                   in_fire;
  logic                   out_fire;

  assign in_fire    = din.valid && din.ready;
  assign out_fire   = dout.valid && dout.ready;
  assign chunk_last = (chunk_cnt == CKW'(CHUNKS - 1));
  assign room       = (digit_count < CW'(MAX_DIGITS));
  assign count_inc  = room ? digit_count + 1'b1 : digit_count;
  assign show_minus = decimal && negative && (count_inc < CW'(MAX_DIGITS));
  assign magnitude  = din.value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-din.value)
                                               : VALUE_WIDTH'(din.value);
  assign rd_addr    = AW'(digit_count - 1'b1);

  // DIV_STEP restoring steps; remainder stays below base, so 4 bits hold it
  always_comb begin
    logic [4:0] t;
    logic       qbit;
    rem_t = rem;
    quo_t = quo;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {rem_t, quo_t[DW-1]};
      if (t >= base_r) begin
        rem_t = 4'(t - base_r);
        qbit  = 1'b1;
      end else begin
        rem_t = t[3:0];
        qbit  = 1'b0;
      end
      quo_t = {quo_t[DW-2:0], qbit};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (chunk_last && (quo_t == '0)) begin
          state_next = show_minus ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        if (dout.ready) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (dout.ready) begin
          state_next = (digit_count == CW'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    din.ready     = (state == ST_IDLE);
    dout.valid    = (state == ST_SIGN) || (state == ST_SEND);
    dout.char_out = (state == ST_SIGN) ? ASCII_MINUS : digit_char(rd_data);
    dout.last     = (state == ST_SEND) && (digit_count == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chunk_cnt   <= '0;
      digit_count <= '0;
      quo         <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        quo         <= DW'(magnitude);
        rem         <= '0;
        chunk_cnt   <= '0;
        digit_count <= '0;
        negative    <= din.value[VALUE_WIDTH-1];
        decimal     <= (din.base inside {[5'd0:5'd1], BASE_DEC});
        if (din.base inside {[5'd0:5'd1], BASE_DEC}) begin
          base_r <= BASE_DEC;
        end else if (din.base > BASE_HEX) begin
          base_r <= BASE_HEX;
        end else begin
          base_r <= din.base;
        end
      end else if (state == ST_DIV) begin
        quo <= quo_t;
        if (chunk_last) begin
          rem         <= '0;
          chunk_cnt   <= '0;
          digit_count <= count_inc;
        end else begin
          rem       <= rem_t;
          chunk_cnt <= chunk_cnt + 1'b1;
        end
      end else if ((state == ST_SEND) && dout.ready) begin
        digit_count <= digit_count - 1'b1;
      end
    end
  end

  // digit RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if ((state == ST_DIV) && chunk_last && room) begin
      digit_store[digit_count[AW-1:0]] <= rem_t;
    end
    rd_data <= digit_store[rd_addr];
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(din.ready && dout.valid))
    else $error("input taken while characters pending");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CW'(MAX_DIGITS))
    else $error("digit count beyond capacity");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_fire && dout.last) |=> din.ready)
    else $error("not idle after final character");

  a_send_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> (digit_count != '0))
    else $error("sending with no digits stored");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ((base_r >= BASE_BIN) && (base_r <= BASE_HEX)))
    else $error("divider base out of range");

endmodule
